FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while reset is asserted
`define GSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// a held transfer keeps its value in the next cycle
`define GSA_ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: src/gsa_pkg.sv
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int MAX_GLYPH_DIM = 16;
    localparam int DIM_W         = 5;
    localparam int CELL_BITS     = 3;
    localparam int STORE_DEPTH   = 32;
    localparam int STORE_AW      = 5;
    localparam int ADDR_W        = 14;
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd8;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_TEXEL = 1'b1
    } func_t;

    typedef struct packed {
        logic [7:0] rem;
        logic [3:0] quot;
    } div_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = 5'd1;
        else if (32'(v) > MAX_GLYPH_DIM)
            r = DIM_W'(MAX_GLYPH_DIM);
        return r;
    endfunction

    // one restoring step, quotient bit sh
    function automatic div_state_t div_step(input div_state_t st,
                                            input logic [DIM_W-1:0] dvs,
                                            input logic [1:0] sh);
        logic [8:0] trial;
        div_state_t r;
        trial = {4'b0, dvs} << sh;
        r = st;
        if ({1'b0, st.rem} >= trial)
        begin
            r.rem      = st.rem - trial[7:0];
            r.quot[sh] = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/gsa_glyph_store.sv
`timescale 1ns / 1ps

module gsa_glyph_store (
    input  logic                         clk,
    input  logic                         we,
    input  logic [gsa_pkg::STORE_AW-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [gsa_pkg::STORE_AW-1:0] raddr,
    output logic [7:0]                   rdata
);
    import gsa_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/glyph_scale_to_atlas_core.sv
`timescale 1ns / 1ps
// items pass the registered stages in order; m_tvalid is the last stage's valid
// throughput: one item per clock unless stalled; the scale division is a restoring
//   divider over two stages at two quotient bits each, the glyph store read takes one
// glyph loads and texels outside the cell give no output transfer
// reset: sizes return to 8 and the pipeline empties; the glyph store is not cleared
module glyph_scale_to_atlas_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // byte_index[4:0], byte_value[12:5], slot[18:13], dest_col[22:19], dest_row[26:23]
    input  logic [31:0] s_tdata,
    // func
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // texel_address[13:0], texel_on[14]
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import gsa_pkg::*;

    logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIM_W-1:0] cfg_next;

    assign cfg_next = clamp_dim(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_RESET;
            src_h_reg <= DIM_RESET;
            dst_w_reg <= DIM_RESET;
            dst_h_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SRC_WIDTH:  src_w_reg <= cfg_next;
                CFG_SRC_HEIGHT: src_h_reg <= cfg_next;
                CFG_DST_WIDTH:  dst_w_reg <= cfg_next;
                CFG_DST_HEIGHT: dst_h_reg <= cfg_next;
            endcase
        end
    end

    // per-stage ready: a stage moves when empty or its successor moves
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || m_tready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // stage 1: input capture
    func_t            func1_reg;
    logic [4:0]       idx1_reg;
    logic [7:0]       val1_reg;
    logic [5:0]       slot1_reg;
    logic [3:0]       col1_reg, row1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (rdy1)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            func1_reg <= func_t'(s_tuser[0]);
            idx1_reg  <= s_tdata[4:0];
            val1_reg  <= s_tdata[12:5];
            slot1_reg <= s_tdata[18:13];
            col1_reg  <= s_tdata[22:19];
            row1_reg  <= s_tdata[26:23];
        end
    end

    // stage 2: bounds, scale numerators, cell origin
    logic       in_cell;
    logic       v2_next;
    logic [8:0] prod_x, prod_y;
    logic [7:0] cy_mul, cx_mul, arow_sum, acol_sum;
    logic       load2_reg;
    logic [4:0] idx2_reg;
    logic [7:0] val2_reg;
    logic [7:0] numx2_reg, numy2_reg;
    logic [6:0] arow2_reg, acol2_reg;

    assign in_cell  = ({1'b0, col1_reg} < dst_w_reg) && ({1'b0, row1_reg} < dst_h_reg);
    assign v2_next  = v1_reg && (func1_reg == FUNC_LOAD || in_cell);
    assign prod_x   = {5'b0, col1_reg} * {4'b0, src_w_reg};
    assign prod_y   = {5'b0, row1_reg} * {4'b0, src_h_reg};
    assign cy_mul   = {5'b0, slot1_reg[5:CELL_BITS]} * {3'b0, dst_h_reg};
    assign cx_mul   = {5'b0, slot1_reg[CELL_BITS-1:0]} * {3'b0, dst_w_reg};
    // cell lines run bottom up
    assign arow_sum = cy_mul + {3'b0, dst_h_reg} - 8'd1 - {4'b0, row1_reg};
    assign acol_sum = cx_mul + {4'b0, col1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (rdy2)
            v2_reg <= v2_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            load2_reg <= (func1_reg == FUNC_LOAD);
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            numx2_reg <= prod_x[7:0];
            numy2_reg <= prod_y[7:0];
            arow2_reg <= arow_sum[6:0];
            acol2_reg <= acol_sum[6:0];
        end
    end

    // stage 3: upper two quotient bits, row base
    div_state_t dx3_next, dy3_next;
    div_state_t dx3_reg, dy3_reg;
    logic       load3_reg;
    logic [4:0] idx3_reg;
    logic [7:0] val3_reg;
    logic [10:0] rowmul3_next, rowmul3_reg;
    logic [6:0] acol3_reg;

    assign dx3_next = div_step(div_step('{rem: numx2_reg, quot: 4'b0}, dst_w_reg, 2'd3),
                               dst_w_reg, 2'd2);
    assign dy3_next = div_step(div_step('{rem: numy2_reg, quot: 4'b0}, dst_h_reg, 2'd3),
                               dst_h_reg, 2'd2);
    assign rowmul3_next = {4'b0, arow2_reg} * {6'b0, dst_w_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (rdy3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            load3_reg   <= load2_reg;
            idx3_reg    <= idx2_reg;
            val3_reg    <= val2_reg;
            dx3_reg     <= dx3_next;
            dy3_reg     <= dy3_next;
            rowmul3_reg <= rowmul3_next;
            acol3_reg   <= acol2_reg;
        end
    end

    // stage 4: lower two quotient bits, texel address
    div_state_t dx4_next, dy4_next;
    logic [ADDR_W-1:0] addr4_next, addr4_reg;
    logic       load4_reg;
    logic [4:0] idx4_reg;
    logic [7:0] val4_reg;
    logic [3:0] sx4_reg, sy4_reg;

    assign dx4_next   = div_step(div_step(dx3_reg, dst_w_reg, 2'd1), dst_w_reg, 2'd0);
    assign dy4_next   = div_step(div_step(dy3_reg, dst_h_reg, 2'd1), dst_h_reg, 2'd0);
    assign addr4_next = ({3'b0, rowmul3_reg} << CELL_BITS) + {7'b0, acol3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (rdy4)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            load4_reg <= load3_reg;
            idx4_reg  <= idx3_reg;
            val4_reg  <= val3_reg;
            sx4_reg   <= dx4_next.quot;
            sy4_reg   <= dy4_next.quot;
            addr4_reg <= addr4_next;
        end
    end

    // stage 5: glyph store access, loads are written here in item order
    logic [7:0] bit_prod, bit_pos;
    logic       store_we;
    logic [7:0] store_rdata;
    logic [2:0] off5_reg;
    logic [ADDR_W-1:0] addr5_reg;

    assign bit_prod = {4'b0, sy4_reg} * {3'b0, src_w_reg};
    assign bit_pos  = bit_prod + {4'b0, sx4_reg};
    assign store_we = v4_reg && load4_reg && rdy5;

    gsa_glyph_store u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (idx4_reg),
        .wdata (val4_reg),
        .re    (rdy5),
        .raddr (bit_pos[7:3]),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (rdy5)
            v5_reg <= v4_reg && !load4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            off5_reg  <= bit_pos[2:0];
            addr5_reg <= addr4_reg;
        end
    end

    // stage 6: output register, leftmost pixel in bit 7
    logic              on6_next, on6_reg;
    logic [ADDR_W-1:0] addr6_reg;

    assign on6_next = store_rdata[~off5_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (rdy6)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            on6_reg   <= on6_next;
            addr6_reg <= addr5_reg;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = {1'b0, on6_reg, addr6_reg};

endmodule

FILE: src/gsa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `GSA_ASSERT(a_out_valid_held, m_tvalid && !m_tready |=> m_tvalid, "output valid dropped")
    `GSA_ASSERT_HOLD(a_out_data_held, m_tvalid && !m_tready, m_tdata, "stalled output changed")
    // a free output side lets every stage move, so the input side is open
    `GSA_ASSERT(a_ready_follows, m_tready |-> s_tready, "input stalled with output ready")
    `GSA_ASSERT(a_empty_ready, !m_tvalid |-> s_tready, "input stalled with output empty")
    `GSA_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[15] == 1'b0, "output pad bit set")

endmodule

bind glyph_scale_to_atlas_core gsa_checker u_gsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
